// File: src/fst_pkg.sv
// Shared types, constants and helpers for the feed schedule timer.
package fst_pkg;

  localparam int unsigned SECONDS_PER_HOUR = 3600;

  localparam int unsigned IntervalW = 8;
  localparam int unsigned FeedLenW  = 16;
  localparam int unsigned CountW    = 20;
  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned DelayW    = 21;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [IntervalW-1:0] IntervalReset = 8'd12;
  localparam logic [FeedLenW-1:0]  FeedLenReset  = 16'd10;
  localparam logic [CountW-1:0]    LimitReset    = 20'd86400;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_FEED   = 2'd1,
    CMD_ONCE   = 2'd2,
    CMD_RELOAD = 2'd3
  } fst_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INTERVAL = 2'd0,
    REG_FEED_LEN = 2'd1,
    REG_LIMIT    = 2'd2
  } fst_reg_e;

  typedef struct packed {
    logic [IntervalW-1:0] interval_hours;
    logic [FeedLenW-1:0]  feeding_length;
    logic [CountW-1:0]    once_delay_limit;
  } fst_cfg_t;

  typedef struct packed {
    fst_cmd_e                  command;
    logic [ElapsedW-1:0]       elapsed;
    logic signed [DelayW-1:0]  once_delay;
  } fst_item_t;

  typedef struct packed {
    logic [CountW-1:0] countdown;
    logic              feeding_active;
    logic              status;
  } fst_result_t;

  function automatic logic [CountW-1:0] reload_value(input logic [IntervalW-1:0] hours);
    logic [31:0] prod;
    prod = 32'(hours) * 32'(SECONDS_PER_HOUR);
    return prod[CountW-1:0];
  endfunction

  localparam logic [CountW-1:0] PeriodicReset = 20'(12 * SECONDS_PER_HOUR);

endpackage

// File: src/fst_core.sv
// Timer state and the single-pass command update.
module fst_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  fst_pkg::fst_cfg_t   cfg_i,
  input  fst_pkg::fst_item_t  item_i,
  output fst_pkg::fst_result_t result_o
);
  import fst_pkg::*;

  logic [CountW-1:0]   periodic_q, periodic_d;
  logic [CountW-1:0]   oneshot_q, oneshot_d;
  logic                once_act_q, once_act_d;
  logic [FeedLenW-1:0] feed_left_q, feed_left_d;
  logic                flag_q, flag_d;
  logic [CountW-1:0]   shown_q, shown_d;
  logic                status;
  logic [CountW-1:0]   el_w;
  logic [CountW-1:0]   reload;
  logic                delay_bad;

  function automatic logic [CountW-1:0] next_count(
    input logic [CountW-1:0]   per,
    input logic [CountW-1:0]   once,
    input logic                act,
    input logic [FeedLenW-1:0] fl,
    input logic                flag
  );
    logic [CountW-1:0] n;
    n = per;
    if (act && (per == '0 || once < per)) n = once;
    if (fl != '0 || flag) n = '0;
    return n;
  endfunction

  assign el_w   = CountW'(item_i.elapsed);
  assign reload = reload_value(cfg_i.interval_hours);
  assign delay_bad = item_i.once_delay[DelayW-1] || (item_i.once_delay == '0) ||
                     (item_i.once_delay[CountW-1:0] > cfg_i.once_delay_limit);

  always_comb begin
    periodic_d  = periodic_q;
    oneshot_d   = oneshot_q;
    once_act_d  = once_act_q;
    feed_left_d = feed_left_q;
    flag_d      = flag_q;
    shown_d     = shown_q;
    status      = 1'b0;
    unique case (item_i.command)
      CMD_TICK: begin
        if (item_i.elapsed != '0) begin
          if (feed_left_q != '0) begin
            if (item_i.elapsed >= feed_left_q) begin
              feed_left_d = '0;
              flag_d      = 1'b0;
              if (periodic_q == '0) periodic_d = reload;
            end else begin
              feed_left_d = feed_left_q - item_i.elapsed;
            end
          end else begin
            periodic_d = (el_w >= periodic_q) ? '0 : periodic_q - el_w;
            if (once_act_q) begin
              oneshot_d = (el_w >= oneshot_q) ? '0 : oneshot_q - el_w;
            end
            if ((once_act_q && oneshot_d == '0) || periodic_d == '0) begin
              feed_left_d = cfg_i.feeding_length;
              flag_d      = 1'b1;
              if (once_act_q && oneshot_d == '0) once_act_d = 1'b0;
            end
          end
          shown_d = next_count(periodic_d, oneshot_d, once_act_d, feed_left_d, flag_d);
        end
      end
      CMD_FEED: begin
        periodic_d  = '0;
        feed_left_d = cfg_i.feeding_length;
        flag_d      = 1'b1;
        shown_d     = '0;
      end
      CMD_ONCE: begin
        if (delay_bad) begin
          status = 1'b1;
        end else begin
          oneshot_d  = item_i.once_delay[CountW-1:0];
          once_act_d = 1'b1;
          shown_d    = next_count(periodic_q, oneshot_d, 1'b1, feed_left_q, flag_q);
        end
      end
      CMD_RELOAD: begin
        periodic_d = reload;
        shown_d    = reload;
      end
      default: ;
    endcase
  end

  assign result_o = '{countdown: shown_d, feeding_active: flag_d, status: status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q  <= PeriodicReset;
      oneshot_q   <= '0;
      once_act_q  <= 1'b0;
      feed_left_q <= '0;
      flag_q      <= 1'b0;
      shown_q     <= PeriodicReset;
    end else if (step_i) begin
      periodic_q  <= periodic_d;
      oneshot_q   <= oneshot_d;
      once_act_q  <= once_act_d;
      feed_left_q <= feed_left_d;
      flag_q      <= flag_d;
      shown_q     <= shown_d;
    end
  end

endmodule

// File: src/feed_schedule_timer.sv
// Feed schedule timer top level: stream ports, configuration registers, item pipeline.
// Result path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the sink accepts results; the state update sits between the two registers.
// A full result register takes the next item as soon as the sink accepts its item.
// Reset (rst_ni low, asynchronous) returns configuration and timers to defaults;
// the periodic countdown restarts at 43200 seconds and no one-shot is pending.
module feed_schedule_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [39:0]                 s_axis_tdata,  // elapsed[15:0], once_delay[36:16], zero pad
  input  logic [1:0]                  s_axis_tuser,  // command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // countdown[19:0], feeding_active[20], pad
  output logic                        m_axis_tuser,  // status
  input  logic                        cfg_we_i,
  input  logic [fst_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fst_pkg::CountW-1:0]  cfg_data_i
);
  import fst_pkg::*;

  fst_cfg_t    cfg_q;
  fst_item_t   item_q;
  logic        in_valid_q;
  fst_result_t res_q;
  fst_result_t res_d;
  logic        out_valid_q;
  logic        step;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{interval_hours: IntervalReset, feeding_length: FeedLenReset,
                 once_delay_limit: LimitReset};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INTERVAL: cfg_q.interval_hours   <= cfg_data_i[IntervalW-1:0];
        REG_FEED_LEN: cfg_q.feeding_length   <= cfg_data_i[FeedLenW-1:0];
        REG_LIMIT:    cfg_q.once_delay_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= '{command: fst_cmd_e'(s_axis_tuser), elapsed: s_axis_tdata[15:0],
                  once_delay: s_axis_tdata[36:16]};
    end
  end

  fst_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.feeding_active, res_q.countdown};
  assign m_axis_tuser  = res_q.status;

endmodule
